// ===== rtl/gsc_pkg.sv =====
// Shared types, constants and scaling helpers of the gas sensor conditioner.
`default_nettype none

package gsc_pkg;

    // Channel numbering, also the order of the gain registers
    localparam int NUM_CH = 4;
    localparam int CH_W   = 2;

    localparam logic [CH_W-1:0] CH_O2  = 2'd0;
    localparam logic [CH_W-1:0] CH_HE  = 2'd1;
    localparam logic [CH_W-1:0] CH_CO2 = 2'd2;
    localparam logic [CH_W-1:0] CH_CO  = 2'd3;

    // Configuration register indexes
    localparam logic [CH_W-1:0] CFG_O2_GAIN  = 2'd0;
    localparam logic [CH_W-1:0] CFG_HE_GAIN  = 2'd1;
    localparam logic [CH_W-1:0] CFG_CO2_GAIN = 2'd2;
    localparam logic [CH_W-1:0] CFG_CO_GAIN  = 2'd3;

    // Field and store widths
    localparam int CODE_W  = 12;
    localparam int GAIN_W  = 16;
    localparam int READ_W  = 16;
    localparam int PCT_W   = 14;
    localparam int CO2_W   = 17;
    localparam int NUM_W   = 14;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd16384;

    // Moving average depth default (power of two)
    localparam int AVG_DEPTH_DEF = 8;

    // Shared multiplier: 29 x 29 bits
    localparam int MUL_W  = 29;
    localparam int PROD_W = 2 * MUL_W;

    // floor(p / (4095 * 16384)): drop 14 bits, then divide by 4095 with
    // reciprocal ceil(2^40 / 4095), exact for dividends below 2^28
    localparam int GAIN_FRAC   = 14;
    localparam int RECIP_SHIFT = 40;
    localparam logic [MUL_W-1:0] RECIP_4095 = 29'd268501009;

    // Clamp limits
    localparam logic [PCT_W-1:0] LIM_PCT = 14'd10000;
    localparam logic [CO2_W-1:0] LIM_CO2 = 17'd100000;
    localparam logic [PCT_W-1:0] LIM_CO  = 14'd10000;

    // Datapath operation per controller step
    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_SCALE = 3'd1,
        OP_GAIN  = 3'd2,
        OP_RECIP = 3'd3,
        OP_ACCUM = 3'd4
    } op_t;

    typedef struct packed {
        logic            load;
        op_t             op;
        logic [CH_W-1:0] chan;
        logic            last;
        logic            publish;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

    // Full-scale numerator of each channel (3.3 V over sensitivity, in units)
    function automatic logic [NUM_W-1:0] scale_num(input logic [CH_W-1:0] chan);
        logic [NUM_W-1:0] num;
        case (chan)
            CH_O2:   num = 14'd10000;
            CH_HE:   num = 14'd10000;
            CH_CO2:  num = 14'd13200;
            CH_CO:   num = 14'd3300;
            default: num = 14'd0;
        endcase
        return num;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/gsc_ram.sv =====
// Generic single-port-write, registered-read RAM.
`default_nettype none

module gsc_ram #(
    parameter int WIDTH = gsc_pkg::READ_W,
    parameter int DEPTH = gsc_pkg::NUM_CH * gsc_pkg::AVG_DEPTH_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/gsc_datapath.sv =====
// Datapath: gain registers, shared multiplier, moving average store and result register.
`default_nettype none

module gsc_datapath #(
    parameter int AVG_DEPTH = gsc_pkg::AVG_DEPTH_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire gsc_pkg::cmd_t                cmd,
    output gsc_pkg::status_t                  status,
    input  wire logic                         cfg_wen,
    input  wire logic [gsc_pkg::CH_W-1:0]     cfg_idx,
    input  wire logic [gsc_pkg::GAIN_W-1:0]   cfg_wdata,
    input  wire logic [gsc_pkg::CODE_W-1:0]   o2_code,
    input  wire logic [gsc_pkg::CODE_W-1:0]   he_code,
    input  wire logic [gsc_pkg::CODE_W-1:0]   co2_code,
    input  wire logic [gsc_pkg::CODE_W-1:0]   co_code,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic      [gsc_pkg::PCT_W-1:0]    o2_level,
    output logic      [gsc_pkg::PCT_W-1:0]    he_level,
    output logic      [gsc_pkg::PCT_W-1:0]    n2_level,
    output logic      [gsc_pkg::CO2_W-1:0]    co2_level,
    output logic      [gsc_pkg::PCT_W-1:0]    co_level
);

    localparam int SLOT_W = $clog2(AVG_DEPTH);
    localparam int SUM_W  = gsc_pkg::READ_W + SLOT_W;
    localparam int ADDR_W = gsc_pkg::CH_W + SLOT_W;
    localparam int T_W    = gsc_pkg::MUL_W - 1;
    localparam int CN_W   = gsc_pkg::CODE_W + gsc_pkg::NUM_W;

    // Configuration and sample registers
    logic [gsc_pkg::GAIN_W-1:0] gain_reg [gsc_pkg::NUM_CH];
    logic [gsc_pkg::CODE_W-1:0] code_reg [gsc_pkg::NUM_CH];

    // Multiplier
    logic [gsc_pkg::MUL_W-1:0]  mul_a;
    logic [gsc_pkg::MUL_W-1:0]  mul_b;
    logic [gsc_pkg::PROD_W-1:0] prod_next;
    logic [gsc_pkg::PROD_W-1:0] prod_reg;

    // Moving average state
    logic [SUM_W-1:0]           sum_reg [gsc_pkg::NUM_CH];
    logic [SUM_W-1:0]           sum_next;
    logic [SLOT_W-1:0]          slot_reg;
    logic                       filled_reg;
    logic [gsc_pkg::READ_W-1:0] reading;
    logic [gsc_pkg::READ_W-1:0] old_reading;
    logic [gsc_pkg::READ_W-1:0] ram_rd_data;
    logic [ADDR_W-1:0]          ram_addr;
    logic [gsc_pkg::READ_W-1:0] avg;

    // Clamped averages
    logic [gsc_pkg::PCT_W-1:0]  o2_avg_reg;
    logic [gsc_pkg::PCT_W-1:0]  he_avg_reg;
    logic [gsc_pkg::CO2_W-1:0]  co2_avg_reg;
    logic [gsc_pkg::PCT_W-1:0]  co_avg_reg;

    // Result register
    logic                       out_valid_reg;
    logic [gsc_pkg::PCT_W:0]    pct_sum;
    logic [gsc_pkg::PCT_W:0]    n2_diff;
    logic [gsc_pkg::PCT_W-1:0]  n2_value;

    // Gain registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < gsc_pkg::NUM_CH; i++)
            begin
                gain_reg[i] <= gsc_pkg::GAIN_RESET;
            end
        end
        else if (cfg_wen)
        begin
            unique case (cfg_idx)
                gsc_pkg::CFG_O2_GAIN:  gain_reg[gsc_pkg::CH_O2]  <= cfg_wdata;
                gsc_pkg::CFG_HE_GAIN:  gain_reg[gsc_pkg::CH_HE]  <= cfg_wdata;
                gsc_pkg::CFG_CO2_GAIN: gain_reg[gsc_pkg::CH_CO2] <= cfg_wdata;
                gsc_pkg::CFG_CO_GAIN:  gain_reg[gsc_pkg::CH_CO]  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Capture the sample set on an accepted beat
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            code_reg[gsc_pkg::CH_O2]  <= o2_code;
            code_reg[gsc_pkg::CH_HE]  <= he_code;
            code_reg[gsc_pkg::CH_CO2] <= co2_code;
            code_reg[gsc_pkg::CH_CO]  <= co_code;
        end
    end

    // Select multiplier operands per step
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            gsc_pkg::OP_SCALE:
            begin
                mul_a = gsc_pkg::MUL_W'(code_reg[cmd.chan]);
                mul_b = gsc_pkg::MUL_W'(gsc_pkg::scale_num(cmd.chan));
            end
            gsc_pkg::OP_GAIN:
            begin
                mul_a = gsc_pkg::MUL_W'(prod_reg[CN_W-1:0]);
                mul_b = gsc_pkg::MUL_W'(gain_reg[cmd.chan]);
            end
            gsc_pkg::OP_RECIP:
            begin
                mul_a = gsc_pkg::MUL_W'(prod_reg[gsc_pkg::GAIN_FRAC +: T_W]);
                mul_b = gsc_pkg::RECIP_4095;
            end
            gsc_pkg::OP_ACCUM: ;
            gsc_pkg::OP_NONE:  ;
            default: ;
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // Hold the product between steps
    always_ff @(posedge clk)
    begin
        if (cmd.op == gsc_pkg::OP_SCALE || cmd.op == gsc_pkg::OP_GAIN ||
            cmd.op == gsc_pkg::OP_RECIP)
        begin
            prod_reg <= prod_next;
        end
    end

    // Quotient of the reciprocal step, saturated to the store width
    always_comb
    begin
        if (|prod_reg[gsc_pkg::PROD_W-1:gsc_pkg::RECIP_SHIFT + gsc_pkg::READ_W])
        begin
            reading = '1;
        end
        else
        begin
            reading = prod_reg[gsc_pkg::RECIP_SHIFT +: gsc_pkg::READ_W];
        end
    end

    // Entries of a slot not yet written since reset read as zero
    assign old_reading = filled_reg ? ram_rd_data : '0;
    assign sum_next    = sum_reg[cmd.chan] - SUM_W'(old_reading) + SUM_W'(reading);
    assign avg         = sum_next[SUM_W-1:SLOT_W];
    assign ram_addr    = {cmd.chan, slot_reg};

    gsc_ram #(
        .WIDTH (gsc_pkg::READ_W),
        .DEPTH (gsc_pkg::NUM_CH * AVG_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (cmd.op == gsc_pkg::OP_ACCUM),
        .wr_addr (ram_addr),
        .wr_data (reading),
        .rd_en   (cmd.op == gsc_pkg::OP_SCALE),
        .rd_addr (ram_addr),
        .rd_data (ram_rd_data)
    );

    // Running sums, write slot and fill flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < gsc_pkg::NUM_CH; i++)
            begin
                sum_reg[i] <= '0;
            end
            slot_reg   <= '0;
            filled_reg <= 1'b0;
        end
        else if (cmd.op == gsc_pkg::OP_ACCUM)
        begin
            sum_reg[cmd.chan] <= sum_next;
            if (cmd.last)
            begin
                slot_reg <= slot_reg + 1'b1;
                if (slot_reg == SLOT_W'(AVG_DEPTH - 1))
                begin
                    filled_reg <= 1'b1;
                end
            end
        end
    end

    // Clamp each channel average
    always_ff @(posedge clk)
    begin
        if (cmd.op == gsc_pkg::OP_ACCUM)
        begin
            case (cmd.chan)
                gsc_pkg::CH_O2:
                    o2_avg_reg <= (avg > gsc_pkg::READ_W'(gsc_pkg::LIM_PCT)) ?
                                  gsc_pkg::LIM_PCT : avg[gsc_pkg::PCT_W-1:0];
                gsc_pkg::CH_HE:
                    he_avg_reg <= (avg > gsc_pkg::READ_W'(gsc_pkg::LIM_PCT)) ?
                                  gsc_pkg::LIM_PCT : avg[gsc_pkg::PCT_W-1:0];
                gsc_pkg::CH_CO2:
                    co2_avg_reg <= (gsc_pkg::CO2_W'(avg) > gsc_pkg::LIM_CO2) ?
                                   gsc_pkg::LIM_CO2 : gsc_pkg::CO2_W'(avg);
                default:
                    co_avg_reg <= (avg > gsc_pkg::READ_W'(gsc_pkg::LIM_CO)) ?
                                  gsc_pkg::LIM_CO : avg[gsc_pkg::PCT_W-1:0];
            endcase
        end
    end

    // Nitrogen balance, floored at zero
    assign pct_sum  = {1'b0, o2_avg_reg} + {1'b0, he_avg_reg};
    assign n2_diff  = {1'b0, gsc_pkg::LIM_PCT} - pct_sum;
    assign n2_value = (pct_sum > {1'b0, gsc_pkg::LIM_PCT}) ? '0 :
                      n2_diff[gsc_pkg::PCT_W-1:0];

    // Result beat: load on publish, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.publish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            o2_level  <= o2_avg_reg;
            he_level  <= he_avg_reg;
            n2_level  <= n2_value;
            co2_level <= co2_avg_reg;
            co_level  <= co_avg_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status.out_free = !out_valid_reg || !out_stall;

`ifndef SYNTH
    a_n2_balance: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (n2_level == '0 ||
            ({1'b0, o2_level} + {1'b0, he_level} + {1'b0, n2_level}) ==
            {1'b0, gsc_pkg::LIM_PCT}))
        else $error("nitrogen balance does not close");

    a_pct_limits: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (o2_level <= gsc_pkg::LIM_PCT && he_level <= gsc_pkg::LIM_PCT &&
                       co_level <= gsc_pkg::LIM_CO && co2_level <= gsc_pkg::LIM_CO2))
        else $error("result level above its clamp limit");

    a_slot_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.op == gsc_pkg::OP_ACCUM && cmd.last) |=> $stable(slot_reg))
        else $error("write slot moved outside the last channel step");
`endif

endmodule

`default_nettype wire

// ===== rtl/gsc_ctrl.sv =====
// Controller: sequences the four channels through scale, gain, reciprocal and accumulate steps.
`default_nettype none

module gsc_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire gsc_pkg::status_t status,
    output gsc_pkg::cmd_t         cmd
);

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_SCALE   = 6'b000010,
        ST_GAIN    = 6'b000100,
        ST_RECIP   = 6'b001000,
        ST_ACCUM   = 6'b010000,
        ST_PUBLISH = 6'b100000
    } state_t;

    state_t                    state_reg;
    state_t                    state_next;
    logic [gsc_pkg::CH_W-1:0]  chan_reg;
    logic [gsc_pkg::CH_W-1:0]  chan_next;
    logic                      last_chan;
    logic                      accept;

    assign accept    = in_valid && (state_reg == ST_IDLE);
    assign last_chan = (chan_reg == gsc_pkg::CH_W'(gsc_pkg::NUM_CH - 1));

    // Next state and channel
    always_comb
    begin
        state_next = state_reg;
        chan_next  = chan_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SCALE;
                    chan_next  = '0;
                end
            end
            ST_SCALE:   state_next = ST_GAIN;
            ST_GAIN:    state_next = ST_RECIP;
            ST_RECIP:   state_next = ST_ACCUM;
            ST_ACCUM:
            begin
                if (last_chan)
                begin
                    state_next = ST_PUBLISH;
                end
                else
                begin
                    state_next = ST_SCALE;
                    chan_next  = chan_reg + 1'b1;
                end
            end
            ST_PUBLISH:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            chan_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            chan_reg  <= chan_next;
        end
    end

    // Decode commands for the datapath
    always_comb
    begin
        cmd.load    = accept;
        cmd.chan    = chan_reg;
        cmd.last    = last_chan;
        cmd.publish = (state_reg == ST_PUBLISH) && status.out_free;
        unique case (state_reg)
            ST_SCALE: cmd.op = gsc_pkg::OP_SCALE;
            ST_GAIN:  cmd.op = gsc_pkg::OP_GAIN;
            ST_RECIP: cmd.op = gsc_pkg::OP_RECIP;
            ST_ACCUM: cmd.op = gsc_pkg::OP_ACCUM;
            default:  cmd.op = gsc_pkg::OP_NONE;
        endcase
    end

    assign in_stall = (state_reg != ST_IDLE);

`ifndef SYNTH
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == ST_SCALE && chan_reg == '0))
        else $error("accepted beat did not start at the first channel");

    a_accum_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ACCUM) |-> ($past(state_reg) == ST_RECIP &&
                                     $past(chan_reg) == chan_reg))
        else $error("accumulate step not preceded by reciprocal step of same channel");

    a_publish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |-> (status.out_free && last_chan))
        else $error("publish while result register busy or channels unfinished");
`endif

endmodule

`default_nettype wire

// ===== rtl/gas_sensor_conditioner_top.sv =====
// Top level of the four-channel gas sensor conditioner with moving average filtering.
`default_nettype none

// Gas sensor conditioner. Each input beat carries four 12-bit ADC codes (O2, He, CO2, CO).
// Every code is scaled to a fixed-point reading (O2/He in 0.01 %, CO2/CO in 0.1 ppm),
// multiplied by its Q2.14 gain register, and folded into an AVG_DEPTH-entry moving average
// (AVG_DEPTH a power of two, 2..64); the result beat carries the clamped averages and the
// nitrogen balance 100 % - O2 - He. A sample set passes, from acceptance to a result beat,
// through four steps per channel (scale, gain, reciprocal divide by 4095, accumulate) on
// one shared 29x29 multiplier, plus the accept in the idle state and a publish step.
// in_stall stays high after acceptance through the channel steps and the publish step,
// longer while a waiting result holds the publish, so a new sample set is taken only
// once the previous one has been published. The result register lets the next
// sample set be accepted while a result still waits. The sample store is a RAM of
// 4 * AVG_DEPTH entries; it needs no clearing pass, since entries read as zero until the
// write slot has wrapped once. Gains reset to 1.0 and should be written only while idle.
module gas_sensor_conditioner_top #(
    parameter int AVG_DEPTH = gsc_pkg::AVG_DEPTH_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_wen,
    input  wire logic [gsc_pkg::CH_W-1:0]     cfg_idx,
    input  wire logic [gsc_pkg::GAIN_W-1:0]   cfg_wdata,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [gsc_pkg::CODE_W-1:0]   o2_code,
    input  wire logic [gsc_pkg::CODE_W-1:0]   he_code,
    input  wire logic [gsc_pkg::CODE_W-1:0]   co2_code,
    input  wire logic [gsc_pkg::CODE_W-1:0]   co_code,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic      [gsc_pkg::PCT_W-1:0]    o2_level,
    output logic      [gsc_pkg::PCT_W-1:0]    he_level,
    output logic      [gsc_pkg::PCT_W-1:0]    n2_level,
    output logic      [gsc_pkg::CO2_W-1:0]    co2_level,
    output logic      [gsc_pkg::PCT_W-1:0]    co_level
);

    gsc_pkg::cmd_t    cmd;
    gsc_pkg::status_t status;

    // Sequencer
    gsc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // Arithmetic, store and result register
    gsc_datapath #(
        .AVG_DEPTH (AVG_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_wen   (cfg_wen),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .o2_code   (o2_code),
        .he_code   (he_code),
        .co2_code  (co2_code),
        .co_code   (co_code),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .o2_level  (o2_level),
        .he_level  (he_level),
        .n2_level  (n2_level),
        .co2_level (co2_level),
        .co_level  (co_level)
    );

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking testbench of the gas sensor conditioner: stimulus, level prediction, result check.

module tb_top;

    import gsc_pkg::*;

    localparam int AVG_DEPTH      = AVG_DEPTH_DEF;
    localparam int MAX_GAP        = 18;
    localparam int SETTLE_CYCLES  = 24;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_SETS     = 125;

    // Clamp limits of the averaged levels
    localparam int unsigned PCT_FULL = 10000;
    localparam int unsigned CO2_FULL = 100000;
    localparam int unsigned CO_FULL  = 10000;

    typedef struct packed {
        logic [CODE_W-1:0] o2;
        logic [CODE_W-1:0] he;
        logic [CODE_W-1:0] co2;
        logic [CODE_W-1:0] co;
    } sample_set_t;

    typedef struct packed {
        logic [PCT_W-1:0] o2;
        logic [PCT_W-1:0] he;
        logic [PCT_W-1:0] n2;
        logic [CO2_W-1:0] co2;
        logic [PCT_W-1:0] co;
    } gas_levels_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cfg_wen   = 1'b0;
    logic [CH_W-1:0]    cfg_idx   = '0;
    logic [GAIN_W-1:0]  cfg_wdata = '0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    logic [CODE_W-1:0]  o2_code   = '0;
    logic [CODE_W-1:0]  he_code   = '0;
    logic [CODE_W-1:0]  co2_code  = '0;
    logic [CODE_W-1:0]  co_code   = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [PCT_W-1:0]   o2_level;
    logic [PCT_W-1:0]   he_level;
    logic [PCT_W-1:0]   n2_level;
    logic [CO2_W-1:0]   co2_level;
    logic [PCT_W-1:0]   co_level;

    // Predictor state: gains, reading history, running sums, shared write slot
    logic [GAIN_W-1:0]  gain_copy [NUM_CH];
    logic [READ_W-1:0]  reading_hist [NUM_CH][AVG_DEPTH];
    int unsigned        channel_sum [NUM_CH];
    int unsigned        hist_slot;

    sample_set_t        sample_sets_pending [$];
    gas_levels_t        expected_levels [$];

    int unsigned        sets_queued    = 0;
    int unsigned        results_seen   = 0;
    int unsigned        mismatches     = 0;
    int unsigned        gain_settings  = 0;
    int unsigned        in_hold        = 0;
    int unsigned        out_hold       = 0;
    int unsigned        quiet_cycles   = 0;
    bit                 in_idle_on     = 1'b0;
    bit                 out_idle_on    = 1'b0;

    gas_sensor_conditioner_top #(
        .AVG_DEPTH (AVG_DEPTH)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .o2_code   (o2_code),
        .he_code   (he_code),
        .co2_code  (co2_code),
        .co_code   (co_code),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .o2_level  (o2_level),
        .he_level  (he_level),
        .n2_level  (n2_level),
        .co2_level (co2_level),
        .co_level  (co_level)
    );

    always #5 clk = ~clk;

    // Full-scale value of a channel in its output unit (3.3 V over sensitivity)
    function automatic int unsigned full_scale_num(input int chan);
        int unsigned num;
        case (chan)
            CH_O2:   num = 10000;
            CH_HE:   num = 10000;
            CH_CO2:  num = 13200;
            CH_CO:   num = 3300;
            default: num = 0;
        endcase
        return num;
    endfunction

    // floor(code * num * gain / (4095 * 2^14)), saturated to the store width
    function automatic logic [READ_W-1:0] scaled_reading(input logic [CODE_W-1:0] code,
                                                         input int unsigned num,
                                                         input logic [GAIN_W-1:0] gain);
        logic [63:0] prod;
        logic [63:0] quot;
        prod = 64'(code) * 64'(num) * 64'(gain);
        quot = prod / (64'd4095 * 64'd16384);
        if (quot > 64'hFFFF)
            quot = 64'hFFFF;
        return quot[READ_W-1:0];
    endfunction

    // Fold one sample set into the averages and queue the levels it yields
    function automatic void predict_levels(input logic [CODE_W-1:0] c_o2,
                                           input logic [CODE_W-1:0] c_he,
                                           input logic [CODE_W-1:0] c_co2,
                                           input logic [CODE_W-1:0] c_co);
        logic [CODE_W-1:0] codes [NUM_CH];
        logic [READ_W-1:0] reading;
        int unsigned       avg [NUM_CH];
        int                balance;
        gas_levels_t       lv;
        codes[CH_O2]  = c_o2;
        codes[CH_HE]  = c_he;
        codes[CH_CO2] = c_co2;
        codes[CH_CO]  = c_co;
        for (int c = 0; c < NUM_CH; c++)
        begin
            reading = scaled_reading(codes[c], full_scale_num(c), gain_copy[c]);
            channel_sum[c] = channel_sum[c] - reading_hist[c][hist_slot] + reading;
            reading_hist[c][hist_slot] = reading;
            avg[c] = channel_sum[c] / AVG_DEPTH;
        end
        hist_slot = (hist_slot + 1) % AVG_DEPTH;

        // Clamp the averages, then form the nitrogen balance
        lv.o2  = PCT_W'((avg[CH_O2] > PCT_FULL) ? PCT_FULL : avg[CH_O2]);
        lv.he  = PCT_W'((avg[CH_HE] > PCT_FULL) ? PCT_FULL : avg[CH_HE]);
        lv.co2 = CO2_W'((avg[CH_CO2] > CO2_FULL) ? CO2_FULL : avg[CH_CO2]);
        lv.co  = PCT_W'((avg[CH_CO] > CO_FULL) ? CO_FULL : avg[CH_CO]);
        balance = int'(PCT_FULL) - int'(lv.o2) - int'(lv.he);
        if (balance < 0)
            balance = 0;
        if (balance > int'(PCT_FULL))
            balance = int'(PCT_FULL);
        lv.n2 = PCT_W'(balance);
        expected_levels.push_back(lv);
    endfunction

    task automatic compare_level(input string field, input int unsigned want,
                                 input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endtask

    task automatic push_set(input logic [CODE_W-1:0] c_o2, input logic [CODE_W-1:0] c_he,
                            input logic [CODE_W-1:0] c_co2, input logic [CODE_W-1:0] c_co);
        sample_set_t s;
        s.o2  = c_o2;
        s.he  = c_he;
        s.co2 = c_co2;
        s.co  = c_co;
        sample_sets_pending.push_back(s);
        sets_queued++;
    endtask

    // Register order follows channel order, so the index doubles as the channel
    task automatic write_gain(input logic [CH_W-1:0] idx, input logic [GAIN_W-1:0] value);
        @(posedge clk);
        cfg_wen   <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= value;
        gain_copy[idx] = value;
        @(posedge clk);
        cfg_wen   <= 1'b0;
    endtask

    task automatic write_all_gains(input logic [GAIN_W-1:0] g_o2, input logic [GAIN_W-1:0] g_he,
                                   input logic [GAIN_W-1:0] g_co2, input logic [GAIN_W-1:0] g_co);
        write_gain(CFG_O2_GAIN, g_o2);
        write_gain(CFG_HE_GAIN, g_he);
        write_gain(CFG_CO2_GAIN, g_co2);
        write_gain(CFG_CO_GAIN, g_co);
        gain_settings++;
    endtask

    // Hold off until every queued set has produced its result, then let the block settle
    task automatic drain_results();
        while (results_seen < sets_queued)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [GAIN_W-1:0] draw_gain();
        logic [GAIN_W-1:0] g;
        case ($urandom_range(0, 5))
            0:       g = '0;
            1:       g = '1;
            2:       g = GAIN_RESET;
            default: g = GAIN_W'($urandom());
        endcase
        return g;
    endfunction

    function automatic logic [CODE_W-1:0] draw_code(input int unsigned floor_code);
        logic [CODE_W-1:0] code;
        case ($urandom_range(0, 7))
            0:       code = '0;
            1:       code = '1;
            default: code = CODE_W'($urandom_range(floor_code, 4095));
        endcase
        return code;
    endfunction

    // Sample set driver: present one beat at a time, with a drawn gap after each while input idling is on
    always @(posedge clk or negedge rst_n)
    begin : sample_driver
        sample_set_t next_set;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            o2_code  <= '0;
            he_code  <= '0;
            co2_code <= '0;
            co_code  <= '0;
            in_hold  <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                predict_levels(o2_code, he_code, co2_code, co_code);
            if (!in_valid || !in_stall)
            begin
                if (in_hold != 0)
                begin
                    in_valid <= 1'b0;
                    in_hold  <= in_hold - 1;
                end
                else if (sample_sets_pending.size() != 0)
                begin
                    next_set = sample_sets_pending.pop_front();
                    o2_code  <= next_set.o2;
                    he_code  <= next_set.he;
                    co2_code <= next_set.co2;
                    co_code  <= next_set.co;
                    in_valid <= 1'b1;
                    in_hold  <= in_idle_on ? $urandom_range(0, MAX_GAP) : 0;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Level monitor: check each result beat, then stall for a drawn number of cycles while output idling is on
    always @(posedge clk or negedge rst_n)
    begin : level_monitor
        int unsigned hold;
        gas_levels_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            out_hold  <= 0;
        end
        else
        begin
            hold = out_hold;
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (expected_levels.size() == 0)
                begin
                    $error("result beat with no sample set waiting for it");
                    mismatches++;
                end
                else
                begin
                    want = expected_levels.pop_front();
                    compare_level("o2_level", want.o2, o2_level);
                    compare_level("he_level", want.he, he_level);
                    compare_level("n2_level", want.n2, n2_level);
                    compare_level("co2_level", want.co2, co2_level);
                    compare_level("co_level", want.co, co_level);
                end
                hold = out_idle_on ? $urandom_range(0, MAX_GAP) : 0;
            end
            if (hold != 0)
            begin
                out_stall <= 1'b1;
                out_hold  <= hold - 1;
            end
            else
            begin
                out_stall <= 1'b0;
                out_hold  <= 0;
            end
        end
    end

    // Watchdog: end the run when no beat moves on either side for too long
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quiet_cycles <= 0;
        end
        else if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no beat for %0d cycles", quiet_cycles);
            $display("[gas_sensor_conditioner_top] ERROR");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin : stimulus
        int unsigned floor_code;
        int unsigned mode;

        // Predictor starts from the reset state of the block
        for (int c = 0; c < NUM_CH; c++)
        begin
            gain_copy[c]   = GAIN_RESET;
            channel_sum[c] = 0;
            for (int d = 0; d < AVG_DEPTH; d++)
                reading_hist[c][d] = '0;
        end
        hist_slot = 0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Reset gains: zero set, warm-up ramp to full scale (nitrogen floors at zero),
        // alternating bit patterns
        push_set('0, '0, '0, '0);
        repeat (AVG_DEPTH) push_set('1, '1, '1, '1);
        push_set(12'hAAA, 12'h555, 12'hAAA, 12'h555);
        push_set(12'h555, 12'hAAA, 12'h555, 12'hAAA);
        drain_results();

        // Largest gains: averages saturate at the clamp limits (CO2 stays below its limit), then decay
        write_all_gains('1, '1, '1, '1);
        repeat (6) push_set('1, '1, '1, '1);
        repeat (2) push_set('0, '0, '0, '0);
        drain_results();

        // Zero gains: every reading drops to zero
        write_all_gains('0, '0, '0, '0);
        push_set('1, '1, '1, '1);
        push_set(12'h800, 12'h001, 12'h7FF, 12'hFFE);
        drain_results();

        // Random phases: new gains each time, varied idling on both sides
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            mode        = p % 4;
            in_idle_on  = (mode < 2);
            out_idle_on = (mode % 2 == 0);
            floor_code  = (p % 3 == 1) ? 3000 : 0;
            write_all_gains(draw_gain(), draw_gain(), draw_gain(), draw_gain());
            repeat (PHASE_SETS)
                push_set(draw_code(floor_code), draw_code(floor_code),
                         draw_code(floor_code), draw_code(floor_code));
            drain_results();
        end

        if (expected_levels.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_levels.size());
            mismatches++;
        end

        $display("Ran %0d sample sets over %0d gain settings: warm-up, saturation, "
                 , sets_queued, gain_settings + 1);
        $display("nitrogen floor and random codes with idling on both sides; %0d mismatches",
                 mismatches);
        if (mismatches == 0)
        begin
            $display("[gas_sensor_conditioner_top] OK");
        end
        else
        begin
            $display("[gas_sensor_conditioner_top] ERROR");
        end
        $finish;
    end

endmodule
